// ----- src/slsd_pkg.sv -----
// Shared types and codes for the static linked-list symmetric-difference block.
// No dependencies; imported by the controller, the datapath and the top level.
package slsd_pkg;

  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 10;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TOGGLE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_CLEARED  = 2'd0;
  localparam logic [1:0] ST_APPENDED = 2'd1;
  localparam logic [1:0] ST_REMOVED  = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  // link store read address select
  localparam logic [1:0] RD_HEAD = 2'd0;
  localparam logic [1:0] RD_FREE = 2'd1;
  localparam logic [1:0] RD_LINK = 2'd2;

  // link store write select
  localparam logic [2:0] WR_NONE   = 3'd0;
  localparam logic [2:0] WR_SWEEP  = 3'd1;
  localparam logic [2:0] WR_NEW    = 3'd2;
  localparam logic [2:0] WR_TAIL   = 3'd3;
  localparam logic [2:0] WR_UNLINK = 3'd4;
  localparam logic [2:0] WR_FREE   = 3'd5;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] member_count;
  } out_item_t;

  typedef struct packed {
    logic       capture;
    logic       init_ptrs;
    logic       take_new;
    logic       walk_start;
    logic       walk_load;
    logic       walk_adv;
    logic       load_result;
    logic [1:0] rd_sel;
    logic [2:0] wr_sel;
    logic [1:0] res_code;
  } cmd_t;

  typedef struct packed {
    logic free_empty;
    logic link_zero;
    logic match;
    logic sweep_last;
  } stat_t;

endpackage

// ----- src/slsd_datapath.sv -----
// Datapath: node value and link stores, list pointers, walk registers, result register.
// Depends on slsd_pkg; driven by slsd_controller through cmd_t and reports stat_t.
module slsd_datapath #(
  parameter int NODE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  slsd_pkg::cmd_t      cmd,
  input  slsd_pkg::in_item_t  in_item,
  output slsd_pkg::stat_t     stat,
  output slsd_pkg::out_item_t out_item
);
  import slsd_pkg::*;

  localparam int IDXW = $clog2(NODE_DEPTH);
  localparam int SEXT_W = SLOT_W + IDXW;
  localparam int CEXT_W = COUNT_W + IDXW;
  localparam logic [IDXW-1:0] HEAD_NODE  = IDXW'(1);
  localparam logic [IDXW-1:0] FIRST_FREE = IDXW'(2);
  localparam logic [IDXW-1:0] LAST_NODE  = IDXW'(NODE_DEPTH - 1);

  logic [VALUE_W-1:0] node_values [NODE_DEPTH];
  logic [IDXW-1:0]    node_links  [NODE_DEPTH];

  logic [1:0]         op;
  logic [VALUE_W-1:0] val;
  logic [IDXW-1:0]    free_head;
  logic [IDXW-1:0]    tail;
  logic [IDXW-1:0]    total;
  logic [IDXW-1:0]    idx;
  logic [IDXW-1:0]    prev;
  logic [IDXW-1:0]    cur;
  logic [IDXW-1:0]    new_node;
  logic [IDXW-1:0]    rd_link;
  logic [VALUE_W-1:0] rd_val;

  logic [IDXW-1:0]    rd_addr;
  logic               wr_en;
  logic [IDXW-1:0]    wr_addr;
  logic [IDXW-1:0]    wr_data;
  logic [IDXW-1:0]    sweep_link;
  logic [IDXW-1:0]    slot_idx;
  logic [SEXT_W-1:0]  slot_ext;
  logic [CEXT_W-1:0]  count_ext;

  // head node and last node end their chains
  assign sweep_link = (idx == HEAD_NODE || idx == LAST_NODE) ? '0 : idx + 1'b1;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_FREE: rd_addr = free_head;
      RD_LINK: rd_addr = rd_link;
      default: rd_addr = HEAD_NODE;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx;
    wr_data = sweep_link;
    unique case (cmd.wr_sel)
      WR_SWEEP: begin
        wr_addr = idx;
        wr_data = sweep_link;
      end
      WR_NEW: begin
        wr_addr = new_node;
        wr_data = '0;
      end
      WR_TAIL: begin
        wr_addr = tail;
        wr_data = new_node;
      end
      WR_UNLINK: begin
        wr_addr = prev;
        wr_data = rd_link;
      end
      WR_FREE: begin
        wr_addr = cur;
        wr_data = free_head;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_links[wr_addr] <= wr_data;
    end
    if (cmd.wr_sel == WR_NEW) begin
      node_values[new_node] <= val;
    end
    rd_link <= node_links[rd_addr];
    rd_val  <= node_values[rd_addr];
  end

  // list pointers and sweep index
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= FIRST_FREE;
      tail      <= HEAD_NODE;
      total     <= '0;
      idx       <= '0;
    end else begin
      if (cmd.capture) begin
        idx <= '0;
      end else if (cmd.wr_sel == WR_SWEEP && idx != LAST_NODE) begin
        idx <= idx + 1'b1;
      end
      if (cmd.init_ptrs) begin
        free_head <= FIRST_FREE;
        tail      <= HEAD_NODE;
        total     <= '0;
      end else begin
        unique case (cmd.wr_sel)
          WR_NEW: free_head <= rd_link;
          WR_TAIL: begin
            tail  <= new_node;
            total <= total + 1'b1;
          end
          WR_FREE: begin
            free_head <= cur;
            if (tail == cur) begin
              tail <= prev;
            end
            if (total != '0) begin
              total <= total - 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= in_item.operation;
      val <= in_item.value;
    end
    if (cmd.take_new) begin
      new_node <= free_head;
    end
    if (cmd.walk_start) begin
      prev <= HEAD_NODE;
    end
    if (cmd.walk_load) begin
      cur <= rd_link;
    end
    if (cmd.walk_adv) begin
      prev <= cur;
      cur  <= rd_link;
    end
  end

  always_comb begin
    unique case (cmd.res_code)
      ST_CLEARED:  slot_idx = HEAD_NODE;
      ST_APPENDED: slot_idx = new_node;
      ST_REMOVED:  slot_idx = cur;
      default:     slot_idx = '0;
    endcase
  end

  assign slot_ext  = SEXT_W'(slot_idx);
  assign count_ext = CEXT_W'(total);

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_item.status       <= cmd.res_code;
      out_item.slot         <= slot_ext[SLOT_W-1:0];
      out_item.member_count <= count_ext[COUNT_W-1:0];
    end
  end

  assign stat.free_empty = (free_head == '0);
  assign stat.link_zero  = (rd_link == '0);
  assign stat.match      = (rd_val == val) && (op == OP_TOGGLE);
  assign stat.sweep_last = (idx == LAST_NODE);

  a_tail_nonzero: assert property (@(posedge clk) disable iff (rst) tail != '0)
    else $error("tail pointer reached end-of-chain node");
  a_free_not_head: assert property (@(posedge clk) disable iff (rst) free_head != HEAD_NODE)
    else $error("head node found on free chain");
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    int'(total) <= NODE_DEPTH - 2)
    else $error("element count exceeds store capacity");

endmodule

// ----- src/slsd_controller.sv -----
// Controller: state machine sequencing sweeps, appends, list walks and removals.
// Depends on slsd_pkg; commands slsd_datapath through cmd_t and reads stat_t.
module slsd_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      in_op,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  slsd_pkg::stat_t stat,
  output slsd_pkg::cmd_t  cmd
);
  import slsd_pkg::*;

  localparam logic [3:0] S_SWEEP     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_APP_RD    = 4'd2;
  localparam logic [3:0] S_APP_LINK  = 4'd3;
  localparam logic [3:0] S_APP_TAIL  = 4'd4;
  localparam logic [3:0] S_WALK_HEAD = 4'd5;
  localparam logic [3:0] S_WALK_NEXT = 4'd6;
  localparam logic [3:0] S_WALK_CMP  = 4'd7;
  localparam logic [3:0] S_REM_FREE  = 4'd8;
  localparam logic [3:0] S_FINISH    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] res;
  logic [1:0] res_next;
  logic       sweep_item;
  logic       sweep_item_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.rd_sel      = RD_HEAD;
    cmd.wr_sel      = WR_NONE;
    cmd.res_code    = res;
    state_next      = state;
    res_next        = res;
    sweep_item_next = sweep_item;
    unique case (state)
      S_SWEEP: begin
        cmd.wr_sel = WR_SWEEP;
        if (stat.sweep_last) begin
          cmd.init_ptrs = 1'b1;
          res_next      = ST_CLEARED;
          state_next    = sweep_item ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture     = 1'b1;
          sweep_item_next = (in_op == OP_CLEAR);
          unique case (in_op)
            OP_CLEAR:  state_next = S_SWEEP;
            OP_APPEND: state_next = S_APP_RD;
            OP_TOGGLE: state_next = S_WALK_HEAD;
            default: begin
              res_next   = ST_REJECTED;
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_APP_RD: begin
        cmd.rd_sel = RD_FREE;
        if (stat.free_empty) begin
          res_next   = ST_REJECTED;
          state_next = S_FINISH;
        end else begin
          cmd.take_new = 1'b1;
          state_next   = S_APP_LINK;
        end
      end
      S_APP_LINK: begin
        cmd.wr_sel = WR_NEW;
        state_next = S_APP_TAIL;
      end
      S_APP_TAIL: begin
        cmd.wr_sel = WR_TAIL;
        res_next   = ST_APPENDED;
        state_next = S_FINISH;
      end
      S_WALK_HEAD: begin
        cmd.rd_sel     = RD_HEAD;
        cmd.walk_start = 1'b1;
        state_next     = S_WALK_NEXT;
      end
      S_WALK_NEXT: begin
        cmd.rd_sel    = RD_LINK;
        cmd.walk_load = 1'b1;
        state_next    = stat.link_zero ? S_APP_RD : S_WALK_CMP;
      end
      S_WALK_CMP: begin
        cmd.rd_sel = RD_LINK;
        if (stat.match) begin
          // bypass the matching node in the same cycle
          cmd.wr_sel = WR_UNLINK;
          state_next = S_REM_FREE;
        end else begin
          cmd.walk_adv = 1'b1;
          if (stat.link_zero) begin
            state_next = S_APP_RD;
          end
        end
      end
      S_REM_FREE: begin
        cmd.wr_sel = WR_FREE;
        res_next   = ST_REMOVED;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      res        <= ST_CLEARED;
      sweep_item <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      res        <= res_next;
      sweep_item <= sweep_item_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("accepted item did not start work");
  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && !(out_valid && out_stall) |=> out_valid && state == S_IDLE)
    else $error("finished item not presented");
  a_tail_after_link: assert property (@(posedge clk) disable iff (rst)
    state == S_APP_TAIL |-> $past(state) == S_APP_LINK)
    else $error("tail update without a taken node");

endmodule

// ----- src/static_list_symmetric_difference.sv -----
// Static linked-list set with clear, append and toggle (symmetric difference).
// Top level: instantiates slsd_controller and slsd_datapath; uses slsd_pkg.
//
// Items enter on in_item (operation, value) with in_valid/in_stall; one result
// per item leaves on out_item (status, slot, member_count) with out_valid/out_stall.
// An item moves when valid is high and stall is low. One item is in work at a
// time; the next is taken in the cycle after the previous result loads into the
// output register, even while that result is stalled.
// Work per accepted item: clear writes one link per node; append reads the free
// chain, writes the new node, writes the tail link and loads the result, or is
// rejected when the free chain is empty; toggle walks the list and removes the
// first matching node, else appends the value as an append does; an unused
// operation is rejected. The walk visits one node per cycle through the single
// read port of each store.
// Reset: rst (synchronous) starts a sweep over every node that rebuilds the
// free chain; in_stall stays high until it ends, and no result is produced.
// A stalled result holds its value; a finished item waits until it can load.
module static_list_symmetric_difference #(
  parameter int NODE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  slsd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output slsd_pkg::out_item_t out_item
);
  import slsd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  slsd_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_item.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  slsd_datapath #(
    .NODE_DEPTH (NODE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
